[rtl/core/rcs_pkg.sv]
// Shared constants, types and helpers of the range-to-prefix splitter.
package rcs_pkg;

   // Fixed field widths of the channels
   localparam int BASE_WIDTH  = 32;
   localparam int PLEN_WIDTH  = 6;
   localparam int TAG_WIDTH   = 16;

   // Default address width and depth of the queue between front and back
   localparam int ADDR_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH        = 2;

   typedef logic [BASE_WIDTH-1:0] base_type;
   typedef logic [PLEN_WIDTH-1:0] plen_type;
   typedef logic [TAG_WIDTH-1:0]  tag_type;

   // Queue status seen by the front (full) and the back (empty)
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

[rtl/core/rcs_front.sv]
// Front end: holds the country register, classifies ranges, queues the wanted ones.
module rcs_front #(
   parameter int ADDR_WIDTH = rcs_pkg::ADDR_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // configuration write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  rcs_pkg::tag_type            csr_data,
   // incoming ranges
   input  logic                        req_valid,
   output logic                        req_stall,
   input  rcs_pkg::base_type           req_range_first,
   input  rcs_pkg::base_type           req_range_last,
   input  rcs_pkg::tag_type            req_country_tag,
   // queue push side
   input  rcs_pkg::q_status_type       q_status,
   output logic                        q_push,
   output logic [ADDR_WIDTH-1:0]       q_first,
   output logic [ADDR_WIDTH:0]         q_count
);

   localparam logic [7:0] LOWER_A    = 8'h61;
   localparam logic [7:0] LOWER_Z    = 8'h7A;
   localparam logic [7:0] CASE_DELTA = 8'h20;

   rcs_pkg::tag_type        want_ff;
   rcs_pkg::tag_type        want_in;
   logic [ADDR_WIDTH-1:0]   first;
   logic [ADDR_WIDTH-1:0]   last;
   logic                    match;

   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= LOWER_A && c <= LOWER_Z) begin
         r = c - CASE_DELTA;
      end
      return r;
   endfunction

   // Store the wanted code already folded to upper case
   assign csr_ready = 1'b1;
   assign want_in   = (csr_valid && csr_ready)
                      ? {fold_upper(csr_data[15:8]), fold_upper(csr_data[7:0])}
                      : want_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         want_ff <= '0;
      end else begin
         want_ff <= want_in;
      end
   end

   // Classify: tag must match and the range must not be reversed
   assign first = ADDR_WIDTH'(req_range_first);
   assign last  = ADDR_WIDTH'(req_range_last);
   assign match = (req_country_tag == want_ff) && (last >= first);

   // Stall only on a full queue; dropped transactions are never pushed
   assign req_stall = q_status.full;
   assign q_push    = req_valid && !req_stall && match;
   assign q_first   = first;
   assign q_count   = {1'b0, last} - {1'b0, first} + {{ADDR_WIDTH{1'b0}}, 1'b1};

endmodule

[rtl/core/rcs_queue.sv]
// Short queue of accepted ranges between the classifier and the splitter.
module rcs_queue #(
   parameter int ADDR_WIDTH = rcs_pkg::ADDR_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [ADDR_WIDTH-1:0]       push_first,
   input  logic [ADDR_WIDTH:0]         push_count,
   input  logic                        pop,
   output logic [ADDR_WIDTH-1:0]       pop_first,
   output logic [ADDR_WIDTH:0]         pop_count,
   output rcs_pkg::q_status_type       status
);

   localparam int DEPTH = rcs_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   logic [ADDR_WIDTH-1:0] first_ff [DEPTH];
   logic [ADDR_WIDTH:0]   count_ff [DEPTH];
   logic [PW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         fill_ff, fill_in;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign status.full  = (fill_ff == CW'(DEPTH));
   assign status.empty = (fill_ff == '0);

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + CW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Write the entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         first_ff[wr_ptr_ff] <= push_first;
         count_ff[wr_ptr_ff] <= push_count;
      end
   end

   assign pop_first = first_ff[rd_ptr_ff];
   assign pop_count = count_ff[rd_ptr_ff];

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push || pop)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !pop)
      else $error("queue read while empty");
`endif

endmodule

[rtl/core/rcs_split.sv]
// Back end: walks one range and emits one aligned prefix block per cycle while rsp_stall is low.
module rcs_split #(
   parameter int ADDR_WIDTH = rcs_pkg::ADDR_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // queue pop side
   input  rcs_pkg::q_status_type       q_status,
   input  logic [ADDR_WIDTH-1:0]       q_first,
   input  logic [ADDR_WIDTH:0]         q_count,
   output logic                        q_pop,
   // outgoing blocks
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output rcs_pkg::base_type           rsp_block_base,
   output rcs_pkg::plen_type           rsp_prefix_length,
   output logic                        rsp_run_last
);

   localparam int RW   = ADDR_WIDTH + 1;
   localparam int KW   = $clog2(RW);
   localparam int LVLS = $clog2(RW);

   logic                     active_ff, active_in;
   logic [ADDR_WIDTH-1:0]    cursor_ff, cursor_in;
   logic [RW-1:0]            remain_ff, remain_in;
   logic                     valid_ff, valid_in;
   rcs_pkg::base_type        base_ff, base_in;
   rcs_pkg::plen_type        plen_ff, plen_in;
   logic                     last_ff, last_in;

   logic [RW-1:0]            cur_ext;
   logic [RW-1:0]            align;
   logic [RW-1:0]            smear;
   logic [RW-1:0]            top;
   logic [RW-1:0]            size;
   logic [KW-1:0]            k;
   logic                     fin;
   logic                     out_load;

   // Largest block aligned at the cursor (a zero cursor aligns to the whole space)
   assign cur_ext = {1'b1, cursor_ff};
   assign align   = cur_ext & (~cur_ext + RW'(1));

   // Highest power of two not above the remaining count
   always_comb begin
      smear = remain_ff;
      for (int i = 0; i < LVLS; i++) begin
         smear = smear | (smear >> (1 << i));
      end
   end
   assign top  = remain_ff & ~(smear >> 1);
   assign size = (align <= remain_ff) ? align : top;
   assign fin  = (size == remain_ff);

   // Encode the one-hot block size
   always_comb begin
      k = '0;
      for (int i = 0; i < RW; i++) begin
         if (size[i]) begin
            k = k | KW'(i);
         end
      end
   end

   // Emit a block whenever the output register is free or being taken
   assign out_load = active_ff && (!valid_ff || !rsp_stall);
   assign q_pop    = !active_ff && !q_status.empty;

   // Load a new range or advance the cursor
   always_comb begin
      active_in = active_ff;
      cursor_in = cursor_ff;
      remain_in = remain_ff;
      if (q_pop) begin
         active_in = 1'b1;
         cursor_in = q_first;
         remain_in = q_count;
      end else if (out_load) begin
         active_in = !fin;
         cursor_in = cursor_ff + size[ADDR_WIDTH-1:0];
         remain_in = remain_ff - size;
      end
   end

   // Output register: hold while stalled, drop once taken
   always_comb begin
      base_in  = base_ff;
      plen_in  = plen_ff;
      last_in  = last_ff;
      valid_in = valid_ff && rsp_stall;
      if (out_load) begin
         valid_in = 1'b1;
         base_in  = rcs_pkg::base_type'(cursor_ff);
         plen_in  = rcs_pkg::plen_type'(ADDR_WIDTH) - rcs_pkg::plen_type'(k);
         last_in  = fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      remain_ff <= remain_in;
      base_ff   <= base_in;
      plen_ff   <= plen_in;
      last_ff   <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_block_base    = base_ff;
   assign rsp_prefix_length = plen_ff;
   assign rsp_run_last      = last_ff;

`ifndef ASSERT_OFF
   a_remain_nonzero: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> remain_ff != '0)
      else $error("splitter active with nothing left to cover");
   a_size_onehot: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> $onehot(size))
      else $error("block size is not a single power of two");
   a_aligned: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (cur_ext & (size - RW'(1))) == '0)
      else $error("emitted block not aligned at cursor");
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      out_load && fin |=> !active_ff && rsp_run_last)
      else $error("run did not end after its final block");
`endif

endmodule

[rtl/core/range_to_cidr_splitter_core.sv]
// Top level of the address range to aligned prefix block splitter.
// Each accepted range whose country tag equals the configured code (folded to
// upper case) and whose last address is not below its first comes out as the
// minimal run of aligned prefix blocks, lowest first, one block per cycle while
// rsp_stall is low, with rsp_run_last set on the final one; other ranges are
// dropped. The front classifies one range per cycle while the queue is not
// full and feeds a two-entry queue; the splitter pops a range from it only
// while idle and then issues its blocks, taking no new range until it has
// issued the final block of the current one. Dropped ranges never enter the
// queue. The csr write port is always ready; write it only while idle.
module range_to_cidr_splitter_core #(
   parameter int ADDR_WIDTH = rcs_pkg::ADDR_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  rcs_pkg::tag_type      csr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rcs_pkg::base_type     req_range_first,
   input  rcs_pkg::base_type     req_range_last,
   input  rcs_pkg::tag_type      req_country_tag,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rcs_pkg::base_type     rsp_block_base,
   output rcs_pkg::plen_type     rsp_prefix_length,
   output logic                  rsp_run_last
);

   rcs_pkg::q_status_type     q_status;
   logic                      q_push;
   logic                      q_pop;
   logic [ADDR_WIDTH-1:0]     push_first;
   logic [ADDR_WIDTH:0]       push_count;
   logic [ADDR_WIDTH-1:0]     pop_first;
   logic [ADDR_WIDTH:0]       pop_count;

   rcs_front #(.ADDR_WIDTH(ADDR_WIDTH)) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_range_first (req_range_first),
      .req_range_last  (req_range_last),
      .req_country_tag (req_country_tag),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_first         (push_first),
      .q_count         (push_count)
   );

   rcs_queue #(.ADDR_WIDTH(ADDR_WIDTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_first (push_first),
      .push_count (push_count),
      .pop        (q_pop),
      .pop_first  (pop_first),
      .pop_count  (pop_count),
      .status     (q_status)
   );

   rcs_split #(.ADDR_WIDTH(ADDR_WIDTH)) u_split (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .q_first           (pop_first),
      .q_count           (pop_count),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_block_base    (rsp_block_base),
      .rsp_prefix_length (rsp_prefix_length),
      .rsp_run_last      (rsp_run_last)
   );

endmodule
